/* sv/super_twisting_emf_observer_defines.svh */
// Assertion macros shared by the observer's checker.
`ifndef SUPER_TWISTING_EMF_OBSERVER_DEFINES_SVH
`define SUPER_TWISTING_EMF_OBSERVER_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off while in reset.
`define STEMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock, off while in reset.
`define STEMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/stemf_pkg.sv */
// Types and constants shared by the super-twisting EMF observer modules.
package stemf_pkg;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Square-root unit widths: radicand is |s| << 15, root fits in 15 bits.
    localparam int RAD_W  = 30;
    localparam int ROOT_W = 15;

    // Configuration register indexes.
    localparam logic [2:0] REG_DECAY     = 3'd0;
    localparam logic [2:0] REG_VGAIN     = 3'd1;
    localparam logic [2:0] REG_ROOT_GAIN = 3'd2;
    localparam logic [2:0] REG_INT_GAIN  = 3'd3;
    localparam logic [2:0] REG_INV_BND   = 3'd4;

    // Saturation limit of the sign term and of the switch output.
    localparam logic signed [15:0] SIGN_MAX = 16'sd32767;

    // Sequencer states, one pass per axis.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SURF,
        ST_SGN_MUL,
        ST_SGN_WB,
        ST_INT_MUL,
        ST_INT_WB,
        ST_DEC_MUL,
        ST_DEC_WB,
        ST_ROOT_WAIT,
        ST_K1_MUL,
        ST_K1_WB,
        ST_Z_MUL,
        ST_Z_WB,
        ST_VOLT_MUL,
        ST_VOLT_WB,
        ST_OUT
    } t_state;

    // Operand pair selected for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SGN,
        MUL_K1,
        MUL_Z,
        MUL_INT,
        MUL_DEC,
        MUL_VOLT
    } t_mul_op;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              busy;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

/* sv/stemf_mul.sv */
// Shared signed multiplier with a registered product.
module stemf_mul
    import stemf_pkg::*;
(
    input  logic                     i_clk,
    input  t_mul_req                 i_req,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // One full-width signed product per cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_req.a) * $signed(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

/* sv/stemf_isqrt.sv */
// Iterative floor square root, one result bit per cycle.
module stemf_isqrt
    import stemf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    logic             r_busy;
    logic [3:0]       r_step;
    logic [RAD_W-1:0] r_x;
    logic [31:0]      r_res;

    logic [31:0] bit_val;
    logic [31:0] trial;
    logic [31:0] x_ext;
    logic [31:0] x_diff;
    logic        fits;

    // Trial value for this step: bit is 4 to the power of the step count.
    always_comb begin
        bit_val = 32'd1 << {r_step, 1'b0};
        trial   = r_res + bit_val;
        x_ext   = {2'b00, r_x};
        fits    = (x_ext >= trial);
        x_diff  = x_ext - trial;
    end

    // Control: busy from start until the last bit has been decided.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_step <= 4'd15;
        end else if (r_busy) begin
            if (r_step == 4'd0) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step - 4'd1;
        end
    end

    // Remainder and partial root.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_req.radicand;
            r_res <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_x   <= x_diff[RAD_W-1:0];
                r_res <= (r_res >> 1) + bit_val;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.root = r_res[ROOT_W-1:0];

endmodule

/* sv/super_twisting_emf_observer.sv */
// Super-twisting sliding-mode EMF observer for the alpha and beta axes. An input
// transaction carries measured currents and reference voltages in Q15; the block
// answers with one output transaction holding the switch outputs and the integrator
// readouts of both axes. The axes are handled one after the other by a sequencer
// around one shared 25x19 multiplier and a square-root unit that decides one bit per
// cycle. Each axis waits for the 16-step square root before the multiplier steps that
// depend on it, and the block accepts no new item until both axes are done. A finished
// result waits in the output register while the block already accepts the next item.
// Configuration is written over the APB port; the user must write it only while the
// block is idle, which the block itself does not enforce.
module super_twisting_emf_observer
    import stemf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // meas_alpha, meas_beta, volt_alpha, volt_beta
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,  // emf_alpha, emf_beta, integ_alpha, integ_beta
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic signed [15:0] r_decay;
    logic signed [15:0] r_vgain;
    logic [14:0]        r_k1;
    logic signed [15:0] r_k2;
    logic [23:0]        r_ib;

    // Observer state and per-item latches.
    logic signed [15:0] r_est   [2];
    logic signed [30:0] r_integ [2];
    logic signed [15:0] r_meas  [2];
    logic signed [15:0] r_volt  [2];
    logic signed [15:0] r_z     [2];

    // Sequencer and working registers.
    t_state             r_state;
    t_state             n_state;
    logic               r_axis;
    logic signed [16:0] r_s;
    logic signed [15:0] r_sg;
    logic [17:0]        r_term;
    logic signed [30:0] r_integ_nx;
    logic signed [16:0] r_fe;

    // Output register.
    logic        r_m_valid;
    logic [63:0] r_m_data;

    // Control decoded from the state.
    t_mul_op  mul_op;
    logic     out_load;
    logic     cfg_wr;

    // Unit interfaces.
    t_mul_req                 mul_req;
    logic signed [PROD_W-1:0] prod;
    t_sqrt_req                sq_req;
    t_sqrt_rsp                sq_rsp;

    // Datapath intermediates.
    logic signed [15:0] cur_est;
    logic signed [15:0] cur_meas;
    logic signed [15:0] cur_volt;
    logic signed [30:0] cur_integ;
    logic signed [16:0] diff;
    logic signed [16:0] s_calc;
    logic [16:0]        s_abs;
    logic [14:0]        mag;
    logic signed [35:0] sg_scaled;
    logic signed [15:0] sg_calc;
    logic signed [19:0] z_sum;
    logic signed [15:0] z_calc;
    logic signed [32:0] integ_sum;
    logic signed [30:0] integ_calc;
    logic signed [16:0] v_minus_z;
    logic signed [15:0] est_calc;

    // Configuration writes and reads.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= '0;
            r_vgain <= '0;
            r_k1    <= '0;
            r_k2    <= '0;
            r_ib    <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_DECAY:     r_decay <= pwdata[15:0];
                REG_VGAIN:     r_vgain <= pwdata[15:0];
                REG_ROOT_GAIN: r_k1    <= pwdata[14:0];
                REG_INT_GAIN:  r_k2    <= pwdata[15:0];
                REG_INV_BND:   r_ib    <= pwdata[23:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_DECAY:     prdata = {{16{r_decay[15]}}, r_decay};
            REG_VGAIN:     prdata = {{16{r_vgain[15]}}, r_vgain};
            REG_ROOT_GAIN: prdata = {17'd0, r_k1};
            REG_INT_GAIN:  prdata = {{16{r_k2[15]}}, r_k2};
            REG_INV_BND:   prdata = {8'd0, r_ib};
            default:       prdata = '0;
        endcase
    end

    // Values of the axis in progress.
    always_comb begin
        cur_est   = r_est[r_axis];
        cur_meas  = r_meas[r_axis];
        cur_volt  = r_volt[r_axis];
        cur_integ = r_integ[r_axis];
    end

    // Sliding surface, clamped to plus or minus one per unit.
    always_comb begin
        diff = {cur_est[15], cur_est} - {cur_meas[15], cur_meas};
        if (diff < -17'sd32768) begin
            s_calc = -17'sd32768;
        end else if (diff > 17'sd32768) begin
            s_calc = 17'sd32768;
        end else begin
            s_calc = diff;
        end
    end

    // Magnitude of the surface, capped to 15 bits, feeds the square root.
    always_comb begin
        s_abs = r_s[16] ? (~r_s + 17'sd1) : r_s;
        mag   = (s_abs > 17'd32767) ? 15'd32767 : s_abs[14:0];
    end

    // Sign term: exact sign, or the scaled surface saturated to the sign limit.
    always_comb begin
        sg_scaled = prod[PROD_W-1:8];
        if (r_ib == 24'd0) begin
            if (r_s > 17'sd0) begin
                sg_calc = SIGN_MAX;
            end else if (r_s < 17'sd0) begin
                sg_calc = -SIGN_MAX;
            end else begin
                sg_calc = '0;
            end
        end else if (sg_scaled > 36'sd32767) begin
            sg_calc = SIGN_MAX;
        end else if (sg_scaled < -36'sd32767) begin
            sg_calc = -SIGN_MAX;
        end else begin
            sg_calc = sg_scaled[15:0];
        end
    end

    // Switch output from the root term and the integrator before its update.
    always_comb begin
        z_sum = {prod[33], prod[33:15]} + {{4{cur_integ[30]}}, cur_integ[30:15]};
        if (z_sum > 20'sd32767) begin
            z_calc = SIGN_MAX;
        end else if (z_sum < -20'sd32767) begin
            z_calc = -SIGN_MAX;
        end else begin
            z_calc = z_sum[15:0];
        end
    end

    // Integrator update, saturated so that its Q15 readout fits 16 bits.
    always_comb begin
        integ_sum = {prod[31], prod[31:0]} + {{2{cur_integ[30]}}, cur_integ};
        if (integ_sum > 33'sd1073741823) begin
            integ_calc = 31'sh3fffffff;
        end else if (integ_sum < -33'sd1073741824) begin
            integ_calc = 31'sh40000000;
        end else begin
            integ_calc = integ_sum[30:0];
        end
    end

    // Current model; the new estimate keeps its low 16 bits.
    always_comb begin
        v_minus_z = {cur_volt[15], cur_volt} - {r_z[r_axis][15], r_z[r_axis]};
        est_calc  = r_fe[15:0] + prod[30:15];
    end

    // Multiplier operand selection.
    always_comb begin
        unique case (mul_op)
            MUL_SGN: begin
                mul_req.a = {1'b0, r_ib};
                mul_req.b = {{2{r_s[16]}}, r_s};
            end
            MUL_K1: begin
                mul_req.a = {10'd0, r_k1};
                mul_req.b = {4'd0, sq_rsp.root};
            end
            MUL_Z: begin
                mul_req.a = {{9{r_sg[15]}}, r_sg};
                mul_req.b = {1'b0, r_term};
            end
            MUL_INT: begin
                mul_req.a = {{9{r_k2[15]}}, r_k2};
                mul_req.b = {{3{r_sg[15]}}, r_sg};
            end
            MUL_DEC: begin
                mul_req.a = {{9{r_decay[15]}}, r_decay};
                mul_req.b = {{3{cur_est[15]}}, cur_est};
            end
            MUL_VOLT: begin
                mul_req.a = {{9{r_vgain[15]}}, r_vgain};
                mul_req.b = {{2{v_minus_z[16]}}, v_minus_z};
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    // Square root starts as soon as the surface is known.
    assign sq_req.start    = (r_state == ST_SGN_MUL);
    assign sq_req.radicand = {mag, 15'd0};

    stemf_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    stemf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_s_tvalid) n_state = ST_SURF;
            ST_SURF:      n_state = ST_SGN_MUL;
            ST_SGN_MUL:   n_state = ST_SGN_WB;
            ST_SGN_WB:    n_state = ST_INT_MUL;
            ST_INT_MUL:   n_state = ST_INT_WB;
            ST_INT_WB:    n_state = ST_DEC_MUL;
            ST_DEC_MUL:   n_state = ST_DEC_WB;
            ST_DEC_WB:    n_state = ST_ROOT_WAIT;
            ST_ROOT_WAIT: if (!sq_rsp.busy) n_state = ST_K1_MUL;
            ST_K1_MUL:    n_state = ST_K1_WB;
            ST_K1_WB:     n_state = ST_Z_MUL;
            ST_Z_MUL:     n_state = ST_Z_WB;
            ST_Z_WB:      n_state = ST_VOLT_MUL;
            ST_VOLT_MUL:  n_state = ST_VOLT_WB;
            ST_VOLT_WB:   n_state = r_axis ? ST_OUT : ST_SURF;
            ST_OUT:       if (!r_m_valid || i_m_tready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        mul_op     = MUL_NONE;
        o_s_tready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE:     o_s_tready = 1'b1;
            ST_SGN_MUL:  mul_op = MUL_SGN;
            ST_INT_MUL:  mul_op = MUL_INT;
            ST_DEC_MUL:  mul_op = MUL_DEC;
            ST_K1_MUL:   mul_op = MUL_K1;
            ST_Z_MUL:    mul_op = MUL_Z;
            ST_VOLT_MUL: mul_op = MUL_VOLT;
            ST_OUT:      out_load = !r_m_valid || i_m_tready;
            default:     ;
        endcase
    end

    // Control state and observer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_axis     <= 1'b0;
            r_est[0]   <= '0;
            r_est[1]   <= '0;
            r_integ[0] <= '0;
            r_integ[1] <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE:    r_axis <= 1'b0;
                ST_Z_WB:    r_integ[r_axis] <= r_integ_nx;
                ST_VOLT_WB: begin
                    r_est[r_axis] <= est_calc;
                    r_axis        <= 1'b1;
                end
                default:    ;
            endcase
        end
    end

    // Working registers written along the per-axis sequence.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    r_meas[0] <= i_s_tdata[15:0];
                    r_meas[1] <= i_s_tdata[31:16];
                    r_volt[0] <= i_s_tdata[47:32];
                    r_volt[1] <= i_s_tdata[63:48];
                end
            end
            ST_SURF:   r_s        <= s_calc;
            ST_SGN_WB: r_sg       <= sg_calc;
            ST_INT_WB: r_integ_nx <= integ_calc;
            ST_DEC_WB: r_fe       <= prod[31:15];
            ST_K1_WB:  r_term     <= prod[29:12];
            ST_Z_WB:   r_z[r_axis] <= z_calc;
            default:   ;
        endcase
    end

    // Output register: holds a finished result until the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {r_integ[1][30:15], r_integ[0][30:15], r_z[1], r_z[0]};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

/* sv/stemf_checker.sv */
// Port-level checker for the observer, bound to the top level.
`include "super_twisting_emf_observer_defines.svh"

module stemf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);

    // A stalled result stays put.
    `STEMF_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "stalled result changed")

    // An accepted item keeps the block busy for the following cycle.
    `STEMF_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready, "ready right after an accepted item")

    // A new result only appears at the end of a computation.
    `STEMF_ASSERT_NOW(a_result_from_work, $rose(o_m_tvalid), $past(!o_s_tready), "result appeared while idle")

    // Switch outputs are saturated symmetrically and never take the most negative 16-bit value.
    `STEMF_ASSERT_NOW(a_emf_range, o_m_tvalid, o_m_tdata[15:0] != 16'h8000 && o_m_tdata[31:16] != 16'h8000, "switch output out of range")

endmodule

bind super_twisting_emf_observer stemf_checker u_stemf_checker (.*);

/* dv/tb.sv */
// Self-checking testbench for the super-twisting EMF observer: stream traffic, APB setup.
module tb;
    import stemf_pkg::*;

    localparam int DRAIN_CYCLES  = 64;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 230;
    localparam int LONG_HOLD     = 400;

    // Tracks the observer state and holds the expected output transactions in order.
    class observer_scoreboard;
        longint decay_f;
        longint volt_g;
        longint k1;
        longint k2ts;
        longint inv_bnd;
        longint est [2];
        longint integ [2];
        logic [63:0] pending_emf [$];
        int errors;

        function new();
            decay_f  = 0;
            volt_g   = 0;
            k1       = 0;
            k2ts     = 0;
            inv_bnd  = 0;
            est[0]   = 0;
            est[1]   = 0;
            integ[0] = 0;
            integ[1] = 0;
            errors   = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_DECAY:     decay_f = $signed(value[15:0]);
                REG_VGAIN:     volt_g  = $signed(value[15:0]);
                REG_ROOT_GAIN: k1      = value[14:0];
                REG_INT_GAIN:  k2ts    = $signed(value[15:0]);
                REG_INV_BND:   inv_bnd = value[23:0];
                default: ;
            endcase
        endfunction

        // One axis of the observer; returns the saturated switch output.
        function longint advance_axis(int ax, longint meas, longint volt);
            longint s, sg, mag, rad, root, trial, term, z, e;
            logic signed [15:0] e16;
            int b;
            s = est[ax] - meas;
            if (s > 32768) s = 32768;
            else if (s < -32768) s = -32768;
            // Exact sign when the boundary register is zero, otherwise a saturated ramp.
            if (inv_bnd == 0) begin
                sg = (s > 0) ? 32767 : ((s < 0) ? -32767 : 0);
            end else begin
                sg = (s * inv_bnd) >>> 8;
                if (sg > 32767) sg = 32767;
                else if (sg < -32767) sg = -32767;
            end
            mag = (s < 0) ? -s : s;
            if (mag > 32767) mag = 32767;
            // Floor square root of the magnitude in Q15, one bit at a time.
            rad = mag << 15;
            root = 0;
            for (b = 14; b >= 0; b--) begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= rad) root = trial;
            end
            term = (k1 * root) >>> 12;
            // The switch uses the integrator value from before this update.
            z = ((term * sg) >>> 15) + (integ[ax] >>> 15);
            integ[ax] = integ[ax] + k2ts * sg;
            if (integ[ax] > 64'sd1073741823) integ[ax] = 64'sd1073741823;
            else if (integ[ax] < -64'sd1073741824) integ[ax] = -64'sd1073741824;
            if (z > 32767) z = 32767;
            else if (z < -32767) z = -32767;
            // Current model update; the estimate wraps to 16 bits.
            e = ((decay_f * est[ax]) >>> 15) + ((volt_g * (volt - z)) >>> 15);
            e16 = e[15:0];
            est[ax] = e16;
            return z;
        endfunction

        function void accept_sample(logic [63:0] d);
            longint za, zb, ra, rb;
            za = advance_axis(0, $signed(d[15:0]), $signed(d[47:32]));
            zb = advance_axis(1, $signed(d[31:16]), $signed(d[63:48]));
            ra = integ[0] >>> 15;
            rb = integ[1] >>> 15;
            pending_emf.push_back({rb[15:0], ra[15:0], zb[15:0], za[15:0]});
        endfunction

        function void check_emf(logic [63:0] d);
            logic [63:0] exp_v;
            string fname;
            int f;
            if (pending_emf.size() == 0) begin
                $display("%0t: unexpected output transaction, actual %h", $time, d);
                errors++;
                return;
            end
            exp_v = pending_emf.pop_front();
            for (f = 0; f < 4; f++) begin
                if (d[16*f +: 16] !== exp_v[16*f +: 16]) begin
                    fname = (f == 0) ? "emf_alpha" : (f == 1) ? "emf_beta" :
                            (f == 2) ? "integ_alpha" : "integ_beta";
                    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname,
                             $signed(exp_v[16*f +: 16]), $signed(d[16*f +: 16]));
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;  // meas_alpha, meas_beta, volt_alpha, volt_beta
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // emf_alpha, emf_beta, integ_alpha, integ_beta
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;

    observer_scoreboard sb;

    always #5 clk = ~clk;

    super_twisting_emf_observer i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Writes one register, reads it back and updates the scoreboard's copy.
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] rd;
        mask = (idx == REG_INV_BND) ? 32'h00FF_FFFF :
               (idx == REG_ROOT_GAIN) ? 32'h0000_7FFF : 32'h0000_FFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, value);
        // Read-back transaction on the same address.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        // The bus goes idle before the next transaction.
        @(posedge clk);
        if ((rd & mask) !== (value & mask)) begin
            $display("%0t: register %0d read-back mismatch, expected %h, actual %h",
                     $time, idx, value & mask, rd & mask);
            sb.errors++;
        end
    endtask

    task automatic configure(input logic [31:0] fd, input logic [31:0] vg,
                             input logic [31:0] kr, input logic [31:0] ki,
                             input logic [31:0] ib);
        reg_write(REG_DECAY, fd);
        reg_write(REG_VGAIN, vg);
        reg_write(REG_ROOT_GAIN, kr);
        reg_write(REG_INT_GAIN, ki);
        reg_write(REG_INV_BND, ib);
    endtask

    // Offers one input transaction, after a random gap while tx_idle is set, and waits for its acceptance.
    task automatic send_item(input logic [63:0] d);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge clk); while (!s_tready);
        sb.accept_sample(d);
    endtask

    // Lets every expected result arrive, then the block settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending_emf.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Tracking items keep the measured current near the estimate so that the
    // surface stays small and the ramp and root terms work in their normal range.
    function automatic logic [63:0] make_item(bit tracking);
        logic [15:0] fld [4];
        longint m;
        int spread;
        int ax;
        if (!tracking) return {$urandom, $urandom};
        for (ax = 0; ax < 2; ax++) begin
            spread = 1 << $urandom_range(0, 12);
            m = sb.est[ax] + longint'($urandom_range(0, 2 * spread)) - spread;
            if (m > 32767) m = 32767;
            else if (m < -32768) m = -32768;
            fld[ax] = m[15:0];
            m = $urandom_range(0, 1) ? longint'($urandom_range(0, 8192)) - 4096
                                      : longint'($urandom_range(0, 65535)) - 32768;
            fld[ax + 2] = m[15:0];
        end
        return {fld[3], fld[2], fld[1], fld[0]};
    endfunction

    function automatic logic [31:0] pick_extreme(logic [31:0] lo, logic [31:0] hi,
                                                 logic [31:0] alt);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            2: return alt;
            default: return 32'h0;
        endcase
    endfunction

    // Receiver: random stalls per transaction while rx_idle is set, plus one long hold-off on request.
    initial begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 16) : 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_emf(m_tdata);
        end
    end

    // Main sequence: reset, directed cases, then randomized phases.
    initial begin
        int phase;
        int n;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Gains at reset: zero surface, field extremes.
        send_item(64'h0);
        send_item(64'h8000_8000_8000_8000);
        send_item(64'h7FFF_7FFF_7FFF_7FFF);
        send_item(64'h7FFF_8000_8000_7FFF);
        send_item(64'hFFFF_0001_0001_FFFF);
        wait_idle();

        // Extreme negative model gains, full gains, exact sign: wrap, clamps, saturation.
        configure(32'h8000, 32'h8000, 32'h7FFF, 32'h7FFF, 32'h0);
        for (n = 0; n < 8; n++)
            send_item(n[0] ? 64'h7FFF_8000_8000_7FFF : 64'h8000_7FFF_7FFF_8000);
        wait_idle();

        // Largest inverse boundary, most negative integral gain.
        configure(32'h7FFF, 32'h7FFF, 32'h4000, 32'h8000, 32'hFF_FFFF);
        for (n = 0; n < 5; n++) send_item(make_item(n[0]));
        wait_idle();

        // Unit ramp with the measurement close to the estimate.
        configure(32'h4000, 32'h0100, 32'h1000, 32'h0010, 32'h100);
        for (n = 0; n < 5; n++) send_item(make_item(1'b1));
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: configure($urandom_range(29000, 32767), $urandom_range(50, 4000),
                             $urandom_range(500, 12000), $urandom_range(0, 3000),
                             $urandom_range(256, 65536));
                1: configure($urandom & 32'hFFFF, $urandom & 32'hFFFF, $urandom & 32'h7FFF,
                             $urandom & 32'hFFFF, $urandom & 32'hFF_FFFF);
                2: configure(pick_extreme(32'h8000, 32'h7FFF, 32'hFFFF),
                             pick_extreme(32'h8000, 32'h7FFF, 32'hFFFF),
                             pick_extreme(32'h1, 32'h7FFF, 32'h4000),
                             pick_extreme(32'h8000, 32'h7FFF, 32'hFFFF),
                             pick_extreme(32'h1, 32'hFF_FFFF, 32'h80_0000));
                default: configure($urandom_range(25000, 32767), $urandom_range(0, 8000),
                                   $urandom_range(0, 20000), $urandom_range(0, 6000), 32'h0);
            endcase
            tx_idle = (phase != 1);
            rx_idle = (phase != 5);
            if (phase == 2) rx_hold = LONG_HOLD;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Now and then the sender stops until the block has answered everything.
                if (phase == 6 && n % 25 == 24) begin
                    s_tvalid <= 1'b0;
                    do @(posedge clk); while (sb.pending_emf.size() != 0);
                end
                send_item(make_item($urandom_range(0, 9) < 7));
            end
            wait_idle();
        end

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #15_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
